>>> hw/rtl/satr_pkg.sv
`timescale 1ns / 1ps
// satr_pkg: types and constants shared by the storage access run tracer
// no dependencies; compiled first

package satr_pkg;

	typedef enum logic [1:0] {
		CMD_RECORD   = 2'd0,
		CMD_READ_BIN = 2'd1,
		CMD_READ_RUN = 2'd2,
		CMD_CLEAR    = 2'd3
	} cmd_t;

	localparam logic [9:0] SECTOR_BYTES = 10'd512;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] lba;
		logic [8:0]  offset;
		logic [9:0]  byte_count;
		logic        is_write;
		logic [31:0] now_ms;
		logic [6:0]  index;
	} item_t;

	typedef struct packed {
		logic [31:0] lba;
		logic [31:0] length;
		logic [31:0] open_ms;
		logic [31:0] last_ms;
		logic        is_partial;
		logic        is_write;
	} run_rec_t;

	typedef struct packed {
		logic [31:0] read_total;
		logic [31:0] write_total;
		logic [31:0] partial_total;
		logic [31:0] overwrite_total;
		logic [6:0]  runs_held;
		run_rec_t    run;
		logic [31:0] bin_value;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic load;
		logic commit;
	} ctl_t;

endpackage

>>> hw/rtl/satr_if.sv
`timescale 1ns / 1ps
// satr_in_if and satr_out_if: valid/ready channels carrying command and result words
// no dependencies

interface satr_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] lba;
	logic [8:0]  offset;
	logic [9:0]  byte_count;
	logic        is_write;
	logic [31:0] now_ms;
	logic [6:0]  index;

	modport source (
		output valid, cmd, lba, offset, byte_count, is_write, now_ms, index,
		input  ready
	);
	modport sink (
		input  valid, cmd, lba, offset, byte_count, is_write, now_ms, index,
		output ready
	);
endinterface

interface satr_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_total;
	logic [31:0] write_total;
	logic [31:0] partial_total;
	logic [31:0] overwrite_total;
	logic [6:0]  runs_held;
	logic [31:0] run_start_lba;
	logic [31:0] run_length;
	logic [31:0] run_first_ms;
	logic [31:0] run_last_ms;
	logic        run_is_write;
	logic        run_is_partial;
	logic [31:0] bin_value;

	modport source (
		output valid, read_total, write_total, partial_total, overwrite_total, runs_held,
		output run_start_lba, run_length, run_first_ms, run_last_ms, run_is_write,
		output run_is_partial, bin_value,
		input  ready
	);
	modport sink (
		input  valid, read_total, write_total, partial_total, overwrite_total, runs_held,
		input  run_start_lba, run_length, run_first_ms, run_last_ms, run_is_write,
		input  run_is_partial, bin_value,
		output ready
	);
endinterface

>>> hw/rtl/storage_access_run_tracer.sv
`timescale 1ns / 1ps
// Storage access run tracer: each command word is handled in a load step that reads the run
// ring and histogram memories, then an execute step that updates counters and writes the
// entries back; the execute step waits while the result register still holds a word. A
// result word is registered, and the next command word is taken while it still waits on the
// output. Clear all goes through the same load and execute steps: histogram bins carry valid
// flags, and run records are only read while held, so no clearing pass is needed.
// depends on satr_pkg, satr_if, satr_ctrl, satr_dp

module storage_access_run_tracer #(
	parameter int RUN_DEPTH = 64,
	parameter int BIN_COUNT = 64,
	parameter int BIN_SHIFT = 10
) (
	input logic        clk,
	input logic        arst_n,
	satr_in_if.sink    in_ch,
	satr_out_if.source out_ch
);
	import satr_pkg::*;

	ctl_t    ctl;
	item_t   item;
	result_t result;
	logic    in_ready;
	logic    out_valid;

	always_comb begin
		item.cmd        = cmd_t'(in_ch.cmd);
		item.lba        = in_ch.lba;
		item.offset     = in_ch.offset;
		item.byte_count = in_ch.byte_count;
		item.is_write   = in_ch.is_write;
		item.now_ms     = in_ch.now_ms;
		item.index      = in_ch.index;
	end

	satr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ready),
		.out_ready (out_ch.ready),
		.out_valid (out_valid),
		.ctl       (ctl)
	);

	satr_dp #(
		.RUN_DEPTH (RUN_DEPTH),
		.BIN_COUNT (BIN_COUNT),
		.BIN_SHIFT (BIN_SHIFT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.item   (item),
		.result (result)
	);

	assign in_ch.ready            = in_ready;
	assign out_ch.valid           = out_valid;
	assign out_ch.read_total      = result.read_total;
	assign out_ch.write_total     = result.write_total;
	assign out_ch.partial_total   = result.partial_total;
	assign out_ch.overwrite_total = result.overwrite_total;
	assign out_ch.runs_held       = result.runs_held;
	assign out_ch.run_start_lba   = result.run.lba;
	assign out_ch.run_length      = result.run.length;
	assign out_ch.run_first_ms    = result.run.open_ms;
	assign out_ch.run_last_ms     = result.run.last_ms;
	assign out_ch.run_is_write    = result.run.is_write;
	assign out_ch.run_is_partial  = result.run.is_partial;
	assign out_ch.bin_value       = result.bin_value;

	// one word in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ready) |=> !in_ready)
		else $error("command word taken while another is in flight");

	a_commit_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> !in_ready)
		else $error("commit outside the execute step");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl.commit))
		else $error("result word shown without a commit");

	a_load_leads_commit: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> !ctl.load)
		else $error("back-to-back loads");

endmodule

>>> hw/rtl/satr_ctrl.sv
`timescale 1ns / 1ps
// satr_ctrl: two-state sequencer for the run tracer, owns the result valid flag
// depends on satr_pkg

module satr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            out_ready,
	output logic            out_valid,
	output satr_pkg::ctl_t  ctl
);
	import satr_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// wait for room in the result register
				if (!out_valid_q || out_ready) begin
					ctl.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> hw/rtl/satr_dp.sv
`timescale 1ns / 1ps
// satr_dp: counters, run ring memory, read histogram memory and result register
// depends on satr_pkg; driven by satr_ctrl through ctl_t

module satr_dp #(
	parameter int RUN_DEPTH = 64,
	parameter int BIN_COUNT = 64,
	parameter int BIN_SHIFT = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  satr_pkg::ctl_t     ctl,
	input  satr_pkg::item_t    item,
	output satr_pkg::result_t  result
);
	import satr_pkg::*;

	localparam int PW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
	localparam int CW = $clog2(RUN_DEPTH + 1);
	localparam int HW = $clog2(BIN_COUNT + 1);
	localparam int SW = ((PW > 7) ? PW : 7) + 2;
	localparam int BW = ((HW > 7) ? HW : 7) + 1;
	localparam logic [PW-1:0] LAST_SLOT = PW'(RUN_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C   = CW'(RUN_DEPTH);
	localparam logic [HW-1:0] OVF_BIN   = HW'(BIN_COUNT);

	// storage
	run_rec_t    run_mem  [RUN_DEPTH];
	logic [31:0] hist_mem [BIN_COUNT + 1];

	// control state
	logic [PW-1:0]    head_q;
	logic [CW-1:0]    held_q;
	logic [31:0]      reads_q;
	logic [31:0]      writes_q;
	logic [31:0]      partials_q;
	logic [31:0]      overwrites_q;
	logic [BIN_COUNT:0] hist_vld_q;

	// operands captured at load
	item_t       item_q;
	run_rec_t    run_rd_q;
	logic [PW-1:0] run_addr_q;
	logic [31:0] hist_rd_q;
	logic [HW-1:0] hist_addr_q;
	logic        hist_hit_q;
	result_t     result_q;

	// load-side addressing
	logic [PW-1:0] newest;
	logic [PW-1:0] oldest;
	logic [SW-1:0] age_sum;
	logic [PW-1:0] age_slot;
	logic [PW-1:0] run_raddr;
	logic [31:0]   lba_shift;
	logic [HW-1:0] lba_bin;
	logic          in_bin_ok;
	logic [HW-1:0] hist_raddr;

	always_comb begin
		newest    = (head_q == '0) ? LAST_SLOT : head_q - 1'b1;
		// once the ring is full the oldest record sits at the head
		oldest    = (held_q == DEPTH_C) ? head_q : '0;
		age_sum   = SW'(oldest) + SW'(item.index);
		if (age_sum >= SW'(RUN_DEPTH)) begin
			age_sum = age_sum - SW'(RUN_DEPTH);
		end
		age_slot  = age_sum[PW-1:0];
		run_raddr = (item.cmd == CMD_READ_RUN) ? age_slot : newest;
		lba_shift = item.lba >> BIN_SHIFT;
		lba_bin   = (lba_shift > 32'(BIN_COUNT)) ? OVF_BIN : HW'(lba_shift);
		in_bin_ok = BW'(item.index) <= BW'(BIN_COUNT);
		if (item.cmd == CMD_READ_BIN) begin
			hist_raddr = in_bin_ok ? HW'(item.index) : '0;
		end else begin
			hist_raddr = lba_bin;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q      <= item;
			run_rd_q    <= run_mem[run_raddr];
			run_addr_q  <= run_raddr;
			hist_rd_q   <= hist_mem[hist_raddr];
			hist_addr_q <= hist_raddr;
			hist_hit_q  <= hist_vld_q[hist_raddr];
		end
	end

	// execute-side update
	logic          partial;
	logic          extend;
	run_rec_t      new_rec;
	logic [PW-1:0] wr_slot;
	logic [31:0]   hist_value;
	logic          age_ok;
	logic          bin_ok;
	logic [PW-1:0] head_n;
	logic [CW-1:0] held_n;
	logic [31:0]   reads_n;
	logic [31:0]   writes_n;
	logic [31:0]   partials_n;
	logic [31:0]   overwrites_n;
	result_t       result_d;

	always_comb begin
		partial = (item_q.offset != '0) || (item_q.byte_count != SECTOR_BYTES);
		extend  = (held_q != '0) && !partial && !run_rd_q.is_partial &&
			(run_rd_q.is_write == item_q.is_write) &&
			((run_rd_q.lba + run_rd_q.length) == item_q.lba);
		if (extend) begin
			new_rec         = run_rd_q;
			new_rec.length  = run_rd_q.length + 32'd1;
			new_rec.last_ms = item_q.now_ms;
			wr_slot         = run_addr_q;
		end else begin
			new_rec.lba        = item_q.lba;
			new_rec.length     = 32'd1;
			new_rec.open_ms    = item_q.now_ms;
			new_rec.last_ms    = item_q.now_ms;
			new_rec.is_partial = partial;
			new_rec.is_write   = item_q.is_write;
			wr_slot            = head_q;
		end
		hist_value = hist_hit_q ? hist_rd_q : 32'd0;
		age_ok     = SW'(item_q.index) < SW'(held_q);
		bin_ok     = BW'(item_q.index) <= BW'(BIN_COUNT);

		head_n       = head_q;
		held_n       = held_q;
		reads_n      = reads_q;
		writes_n     = writes_q;
		partials_n   = partials_q;
		overwrites_n = overwrites_q;
		unique case (item_q.cmd)
			CMD_RECORD: begin
				if (item_q.is_write) begin
					writes_n = writes_q + 32'd1;
				end else begin
					reads_n = reads_q + 32'd1;
				end
				if (partial) begin
					partials_n = partials_q + 32'd1;
				end
				if (!extend) begin
					head_n = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
					if (held_q == DEPTH_C) begin
						overwrites_n = overwrites_q + 32'd1;
					end else begin
						held_n = held_q + 1'b1;
					end
				end
			end
			CMD_CLEAR: begin
				head_n       = '0;
				held_n       = '0;
				reads_n      = '0;
				writes_n     = '0;
				partials_n   = '0;
				overwrites_n = '0;
			end
			CMD_READ_BIN, CMD_READ_RUN: begin
			end
		endcase

		result_d.read_total      = reads_n;
		result_d.write_total     = writes_n;
		result_d.partial_total   = partials_n;
		result_d.overwrite_total = overwrites_n;
		result_d.runs_held       = 7'(held_n);
		result_d.run             = '0;
		result_d.bin_value       = '0;
		if (item_q.cmd == CMD_RECORD) begin
			result_d.run = new_rec;
		end else if (item_q.cmd == CMD_READ_RUN && age_ok) begin
			result_d.run = run_rd_q;
		end else if (item_q.cmd == CMD_READ_BIN && bin_ok) begin
			result_d.bin_value = hist_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			held_q       <= '0;
			reads_q      <= '0;
			writes_q     <= '0;
			partials_q   <= '0;
			overwrites_q <= '0;
			hist_vld_q   <= '0;
		end else if (ctl.commit) begin
			head_q       <= head_n;
			held_q       <= held_n;
			reads_q      <= reads_n;
			writes_q     <= writes_n;
			partials_q   <= partials_n;
			overwrites_q <= overwrites_n;
			if (item_q.cmd == CMD_CLEAR) begin
				hist_vld_q <= '0;
			end else if (item_q.cmd == CMD_RECORD && !item_q.is_write) begin
				hist_vld_q[hist_addr_q] <= 1'b1;
			end
		end
	end

	// write-back of run and histogram entries
	always_ff @(posedge clk) begin
		if (ctl.commit && item_q.cmd == CMD_RECORD) begin
			run_mem[wr_slot] <= new_rec;
			if (!item_q.is_write) begin
				hist_mem[hist_addr_q] <= hist_value + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			result_q <= result_d;
		end
	end

	assign result = result_q;

endmodule
